// ===== sv/tsl_pkg.sv =====
// Shared types, constants and the sine table generator for the timed slew limiter.
package tsl_pkg;

   localparam int MULT_W         = 16;
   localparam int TIME_FRAC_BITS = 8;
   localparam int SINE_W         = 17;
   localparam int SINE_FRAC_BITS = 16;
   localparam longint unsigned SINE_ONE    = 64'd65536;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   localparam int CSR_IDX_W = 1;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_MODE      = 1'b0;
   localparam csr_idx_type CSR_TIME_MULT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMP,
      ST_TMUL,
      ST_TSAT,
      ST_DSET,
      ST_DIV,
      ST_LIN,
      ST_ROM,
      ST_SLOAD,
      ST_SMUL,
      ST_SADD,
      ST_CLAMP,
      ST_OUT
   } state_type;

   // quarter-wave entry in Q1.16, Taylor series in Q30
   function automatic logic [SINE_W-1:0] sine_rom_entry(int unsigned idx,
                                                        int unsigned table_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned e;
      longint sum;
      x    = (PI_HALF_Q30 * longint'(idx)) >> table_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      e = (longint'(sum) + 64'd8192) >> 14;
      if (e > SINE_ONE) begin
         e = SINE_ONE;
      end
      return SINE_W'(e);
   endfunction

endpackage

// ===== sv/timed_slew_limiter_core.sv =====
// Timed slew limiter: sequencer with one shared multiplier, divider and sine ROM.
//
// Usage:
//   req channel (req_tvalid/req_tready/req_tdata) carries one input word: level,
//   rise_time, fall_time. rsp channel returns one word per input: the slewed
//   sample. csr writes mode (index 0), time_mult (index 1, Q8.8). csr_ready is
//   always high; the user makes writes while the block is idle (not enforced).
// Timing:
//   One word is processed at a time; req_tready is high only when idle.
//   Equal input goes from compare to output; zero time adds time multiply and
//   saturate. A linear ramp divides, steps and clamps; a sine ramp divides,
//   passes the registered ROM and multiplier, adds and clamps. The restoring
//   divider makes one quotient bit per cycle over DIV_W = max(SAMPLE_BITS +
//   FRAC_BITS + 1, TIME_BITS + SINE_TABLE_BITS) bits (34 at defaults).
// Reset: state values clear to zero, mode to linear, time_mult to 1.0.
// Stall: a finished result waits in the output register; while it is not
//   taken the next word is accepted and worked up to its final write.
module timed_slew_limiter_core #(
   parameter int SAMPLE_BITS     = 24,
   parameter int FRAC_BITS       = 8,
   parameter int TIME_BITS       = 24,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // level, rise_time, fall_time
   input  logic [((SAMPLE_BITS+2*TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // slewed
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]             rsp_tdata,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  tsl_pkg::csr_idx_type                         csr_index,
   input  logic [tsl_pkg::MULT_W-1:0]                   csr_data
);
   import tsl_pkg::*;

   localparam int VAL_W     = SAMPLE_BITS + FRAC_BITS;
   localparam int DLT_W     = VAL_W + 1;
   localparam int NXT_W     = VAL_W + 2;
   localparam int ROM_N     = 1 << SINE_TABLE_BITS;
   localparam int ROM_DEPTH = ROM_N + 1;
   localparam int ADDR_W    = SINE_TABLE_BITS + 1;
   localparam int MUL_A_W   = (TIME_BITS > DLT_W) ? TIME_BITS : DLT_W;
   localparam int MUL_B_W   = SINE_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int DIV_W     = (DLT_W > TIME_BITS + SINE_TABLE_BITS) ?
                              DLT_W : TIME_BITS + SINE_TABLE_BITS;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int RSP_W     = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef logic [SINE_W-1:0] rom_type [ROM_DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r[i] = sine_rom_entry(i, SINE_TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   state_type state_ff, state_in;
   logic mode_ff, mode_in;
   logic [MULT_W-1:0] mult_ff, mult_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic signed [VAL_W-1:0] held_ff, held_in;
   logic signed [VAL_W-1:0] start_ff, start_in;
   logic signed [DLT_W-1:0] delta_ff, delta_in;
   logic [TIME_BITS-1:0] rtime_ff, rtime_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] level_ff, level_in;
   logic signed [TIME_BITS-1:0] rise_ff, rise_in;
   logic signed [TIME_BITS-1:0] fall_ff, fall_in;
   logic [TIME_BITS-1:0] tval_ff, tval_in;
   logic dir_ff, dir_in;
   logic [MUL_A_W-1:0] mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0] mul_b_ff, mul_b_in;
   logic [PROD_W-1:0] prod_ff;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SINE_W-1:0] rom_q_ff;
   logic neg_ff, neg_in;
   logic signed [NXT_W-1:0] next_ff, next_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic signed [VAL_W-1:0] lv;
   logic signed [TIME_BITS-1:0] raw_t;
   logic [TIME_BITS-1:0] abs_t;
   logic [TIME_BITS-1:0] scaled_t;
   logic signed [DLT_W-1:0] new_delta;
   logic [DLT_W-1:0] delta_mag;
   logic [TIME_BITS:0] rem_sh;
   logic rem_ge;
   logic [1:0] quad;
   logic [SINE_TABLE_BITS-1:0] phase_r;
   logic [ADDR_W-1:0] rom_addr;
   logic signed [NXT_W-1:0] lin_step;
   logic signed [NXT_W-1:0] sine_off;
   logic signed [NXT_W-1:0] tgt_ext;
   logic signed [NXT_W-1:0] clamped;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   assign lv        = VAL_W'(level_ff) <<< FRAC_BITS;
   assign raw_t     = (lv > cur_ff) ? rise_ff : fall_ff;
   assign abs_t     = raw_t[TIME_BITS-1] ? TIME_BITS'(-raw_t) : TIME_BITS'(raw_t);
   assign scaled_t  = (|prod_ff[PROD_W-1:TIME_BITS+TIME_FRAC_BITS]) ? '1 :
                      prod_ff[TIME_BITS+TIME_FRAC_BITS-1:TIME_FRAC_BITS];
   assign new_delta = DLT_W'(lv) - DLT_W'(cur_ff);
   assign delta_mag = delta_ff[DLT_W-1] ? DLT_W'(-delta_ff) : DLT_W'(delta_ff);
   assign rem_sh    = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_ge    = (rem_sh >= {1'b0, tval_ff});
   assign quad      = quo_ff[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
   assign phase_r   = quo_ff[SINE_TABLE_BITS-1:0];
   assign rom_addr  = quad[0] ? ADDR_W'(ROM_N) - ADDR_W'(phase_r) : ADDR_W'(phase_r);
   assign lin_step  = delta_ff[DLT_W-1] ? -NXT_W'(quo_ff[DLT_W-1:0]) :
                      NXT_W'(quo_ff[DLT_W-1:0]);
   assign sine_off  = NXT_W'(prod_ff >> SINE_FRAC_BITS);
   assign tgt_ext   = NXT_W'(held_ff);
   assign clamped   = (dir_ff ? (next_ff > tgt_ext) : (next_ff < tgt_ext)) ?
                      tgt_ext : next_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      mult_in      = mult_ff;
      cur_in       = cur_ff;
      held_in      = held_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      rtime_in     = rtime_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      level_in     = level_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      tval_in      = tval_ff;
      dir_in       = dir_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      next_in      = next_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:      mode_in = csr_data[0];
            CSR_TIME_MULT: mult_in = csr_data;
            default:       mult_in = mult_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               level_in = req_tdata[SAMPLE_BITS-1:0];
               rise_in  = req_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
               fall_in  = req_tdata[SAMPLE_BITS+2*TIME_BITS-1:SAMPLE_BITS+TIME_BITS];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            dir_in   = (lv > cur_ff);
            mul_a_in = MUL_A_W'(abs_t);
            mul_b_in = MUL_B_W'(mult_ff);
            state_in = (lv == cur_ff) ? ST_OUT : ST_TMUL;
         end
         ST_TMUL: begin
            state_in = ST_TSAT;
         end
         ST_TSAT: begin
            tval_in = scaled_t;
            if (scaled_t == '0) begin
               cur_in   = lv;
               held_in  = lv;
               state_in = ST_OUT;
            end else begin
               if (lv != held_ff) begin
                  held_in  = lv;
                  delta_in = new_delta;
                  start_in = cur_ff;
                  if (mode_ff) begin
                     rtime_in = TIME_BITS'(1);
                  end
               end
               state_in = ST_DSET;
            end
         end
         ST_DSET: begin
            quo_in   = mode_ff ? DIV_W'(rtime_ff) << SINE_TABLE_BITS : DIV_W'(delta_mag);
            rem_in   = '0;
            cnt_in   = CNT_W'(DIV_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = rem_ge ? TIME_BITS'(rem_sh - {1'b0, tval_ff}) : TIME_BITS'(rem_sh);
            quo_in = {quo_ff[DIV_W-2:0], rem_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = mode_ff ? ST_ROM : ST_LIN;
            end
         end
         ST_LIN: begin
            next_in  = NXT_W'(cur_ff) + lin_step;
            state_in = ST_CLAMP;
         end
         ST_ROM: begin
            neg_in   = delta_ff[DLT_W-1] ^ quad[1];
            state_in = ST_SLOAD;
         end
         ST_SLOAD: begin
            mul_a_in = MUL_A_W'(delta_mag);
            mul_b_in = rom_q_ff;
            state_in = ST_SMUL;
         end
         ST_SMUL: begin
            state_in = ST_SADD;
         end
         ST_SADD: begin
            next_in = NXT_W'(start_ff) + (neg_ff ? -sine_off : sine_off);
            if (rtime_ff < tval_ff) begin
               rtime_in = rtime_ff + TIME_BITS'(1);
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (clamped[NXT_W-1:VAL_W-1] == '0 || clamped[NXT_W-1:VAL_W-1] == '1) begin
               cur_in = VAL_W'(clamped);
            end else if (clamped[NXT_W-1]) begin
               cur_in = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
               cur_in = {1'b0, {(VAL_W-1){1'b1}}};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = SAMPLE_BITS'(cur_ff >>> FRAC_BITS);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         mult_ff      <= MULT_W'(256);
         cur_ff       <= '0;
         held_ff      <= '0;
         start_ff     <= '0;
         delta_ff     <= '0;
         rtime_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         mult_ff      <= mult_in;
         cur_ff       <= cur_in;
         held_ff      <= held_in;
         start_ff     <= start_in;
         delta_ff     <= delta_in;
         rtime_ff     <= rtime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      rise_ff     <= rise_in;
      fall_ff     <= fall_in;
      tval_ff     <= tval_in;
      dir_ff      <= dir_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff);
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      next_ff     <= next_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

endmodule

// ===== sv/tsl_checker.sv =====
// Port-level assertions for the timed slew limiter, bound to the top level.
module tsl_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a word is in flight");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("rsp word raised without work in flight");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind timed_slew_limiter_core tsl_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_tsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_timed_slew_limiter_core.sv =====
// Self-checking testbench for timed_slew_limiter_core: random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb_timed_slew_limiter_core;
   import tsl_pkg::*;

   localparam int SAMPLE_W = 24;
   localparam int TIME_W   = 24;
   localparam int FRAC_W   = 8;
   localparam int ROM_BITS = 10;
   localparam int REQ_W    = ((SAMPLE_W + 2*TIME_W + 7)/8)*8;
   localparam int RSP_W    = ((SAMPLE_W + 7)/8)*8;
   localparam longint VAL_MAX  = (64'sd1 <<< (SAMPLE_W + FRAC_W - 1)) - 1;
   localparam longint VAL_MIN  = -VAL_MAX - 1;
   localparam longint TIME_MAX = (64'sd1 <<< TIME_W) - 1;
   localparam longint UNIT_Q16 = 65536;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [SAMPLE_W-1:0] LEVEL_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] LEVEL_MIN = 24'sh800000;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] level;
      logic signed [TIME_W-1:0]   rise;
      logic signed [TIME_W-1:0]   fall;
   } slew_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_idx_type         csr_index = CSR_MODE;
   logic [MULT_W-1:0]   csr_data = '0;

   // predictor state and register copies
   longint slew_val     = 0;
   longint slew_goal    = 0;
   longint ramp_origin  = 0;
   longint ramp_delta_q = 0;
   longint sine_step    = 0;
   bit     sine_mode    = 1'b0;
   longint time_mult    = 256;

   slew_req_type       pending[$];
   logic [SAMPLE_W-1:0] slew_expect[$];
   slew_req_type       in_flight;
   int                 burst_left = 1;
   int                 gap_left = 0;
   logic [31:0]        stall_pat = '1;
   int                 pat_pos = 0;
   int                 idle_cycles = 0;
   int                 fail_count = 0;

   timed_slew_limiter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint scale_time(input logic signed [TIME_W-1:0] raw);
      longint mag;
      longint t;
      mag = (raw < 0) ? -longint'(raw) : longint'(raw);
      t = (mag * time_mult) >>> 8;
      return (t > TIME_MAX) ? TIME_MAX : t;
   endfunction

   // quarter-wave sine in Q1.16 from a Q30 Taylor series
   function automatic longint quarter_sine(input longint idx);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint e;
      x    = (HALF_PI_Q30 * idx) >> ROM_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / (2*k*(2*k + 1));
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      e = (sum + 8192) >>> 14;
      return (e > UNIT_Q16) ? UNIT_Q16 : e;
   endfunction

   function automatic longint ramp_sine(input longint t, input longint span);
      longint p;
      longint q;
      longint r;
      longint e;
      p = (t <<< ROM_BITS) / span;
      q = (p >>> ROM_BITS) & 3;
      r = p & ((64'sd1 <<< ROM_BITS) - 1);
      e = q[0] ? quarter_sine((64'sd1 <<< ROM_BITS) - r) : quarter_sine(r);
      return q[1] ? -e : e;
   endfunction

   function automatic logic [SAMPLE_W-1:0] step_slew(input slew_req_type w);
      longint lv;
      longint rt;
      longint ft;
      longint span;
      longint s;
      longint dm;
      longint sm;
      longint off;
      logic   rising;
      lv = longint'(w.level) * (64'sd1 <<< FRAC_W);
      rt = scale_time(w.rise);
      ft = scale_time(w.fall);
      if (lv != slew_val) begin
         rising = lv > slew_val;
         span = rising ? rt : ft;
         if (span == 0) begin
            slew_val  = lv;
            slew_goal = lv;
         end else begin
            if (lv != slew_goal) begin
               slew_goal    = lv;
               ramp_delta_q = slew_goal - slew_val;
               ramp_origin  = slew_val;
               if (sine_mode) begin
                  sine_step = 1;
               end
            end
            if (!sine_mode) begin
               slew_val = slew_val + ramp_delta_q / span;
            end else begin
               s   = ramp_sine(sine_step, span);
               dm  = (ramp_delta_q < 0) ? -ramp_delta_q : ramp_delta_q;
               sm  = (s < 0) ? -s : s;
               off = (dm * sm) / UNIT_Q16;
               if ((ramp_delta_q < 0) != (s < 0)) begin
                  off = -off;
               end
               slew_val = ramp_origin + off;
               if (sine_step < span) begin
                  sine_step++;
               end
            end
            if (rising && slew_val > slew_goal) begin
               slew_val = slew_goal;
            end
            if (!rising && slew_val < slew_goal) begin
               slew_val = slew_goal;
            end
            if (slew_val > VAL_MAX) begin
               slew_val = VAL_MAX;
            end
            if (slew_val < VAL_MIN) begin
               slew_val = VAL_MIN;
            end
         end
      end
      return SAMPLE_W'(slew_val >>> FRAC_W);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return LEVEL_MAX;
         1: return LEVEL_MIN;
         2: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         5: return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [TIME_W-1:0] pick_time();
      int t;
      t = $urandom_range(1, 40);
      case ($urandom_range(0, 7))
         0: return '0;
         5: return TIME_W'($urandom);
         6: return 24'sh7FFFFF;
         7: return 24'sh800000;
         default: return $urandom_range(0, 1) ? TIME_W'(-t) : TIME_W'(t);
      endcase
   endfunction

   task automatic queue_word(input logic signed [SAMPLE_W-1:0] lvl,
                             input logic signed [TIME_W-1:0] rt,
                             input logic signed [TIME_W-1:0] ft);
      slew_req_type w;
      w.level = lvl;
      w.rise  = rt;
      w.fall  = ft;
      pending.push_back(w);
   endtask

   task automatic queue_run(input logic signed [SAMPLE_W-1:0] lvl,
                            input logic signed [TIME_W-1:0] rt,
                            input logic signed [TIME_W-1:0] ft, input int count);
      for (int i = 0; i < count; i++) begin
         queue_word(lvl, rt, ft);
      end
   endtask

   // sampled mid-cycle so the sender's valid has settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending.size() != 0 || req_tvalid || slew_expect.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [MULT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) begin
         sine_mode = value[0];
      end else begin
         time_mult = value;
      end
   endtask

   // sender: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            slew_expect.push_back(step_slew(in_flight));
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               case ($urandom_range(0, 3))
                  1: gap_left = $urandom_range(1, 4);
                  2: gap_left = $urandom_range(5, 60);
                  default: gap_left = 0;
               endcase
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
               in_flight = pending.pop_front();
               req_tdata  <= {in_flight.fall, in_flight.rise, in_flight.level};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each slewed word, stalls from a rotating pattern
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (slew_expect.size() == 0) begin
               $error("slewed: no word expected, actual %0d", $signed(rsp_tdata[SAMPLE_W-1:0]));
               fail_count++;
            end else begin
               want = slew_expect.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want) begin
                  $error("slewed mismatch: expected %0d, actual %0d", $signed(want),
                         $signed(rsp_tdata[SAMPLE_W-1:0]));
                  fail_count++;
               end
            end
         end
         pat_pos = (pat_pos + 1) % 32;
         if (pat_pos == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pat = '1;
               1: stall_pat = $urandom;
               2: stall_pat = $urandom | $urandom;
               default: stall_pat = 32'h0000FFFF;
            endcase
         end
         rsp_tready <= stall_pat[pat_pos];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_timed_slew_limiter_core failed");
            $finish;
         end
      end
   end

   initial begin
      bit                         phase_mode[9];
      logic [MULT_W-1:0]          phase_mult[9];
      logic signed [SAMPLE_W-1:0] lvl;
      logic signed [TIME_W-1:0]   rt;
      logic signed [TIME_W-1:0]   ft;
      int                         n;
      int                         hold;
      phase_mode = '{0, 1, 0, 1, 0, 1, 0, 1, 1};
      phase_mult = '{16'd0, 16'd65535, 16'd65535, 16'd16, 16'd128, 16'd256, 16'd512,
                     16'd0, 16'd256};
      phase_mult[8] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // linear ramp at reset settings: equal input, jump, fall, stall, reversal
      queue_word(24'sd0, 24'sd5, 24'sd5);
      queue_word(LEVEL_MAX, 24'sd0, 24'sd9);
      queue_run(LEVEL_MIN, 24'sd1, -24'sd3, 3);
      queue_run(-24'sd8388607, 24'sh7FFFFF, 24'sh800000, 2);
      queue_run(LEVEL_MAX, 24'sd4, 24'sd4, 2);
      queue_word(24'sd0, -24'sd4, -24'sd4);
      wait_drained();

      // sine ramp to the end of its time, then time shrunk below the counter
      write_csr(CSR_MODE, 16'd1);
      write_csr(CSR_TIME_MULT, 16'd256);
      queue_run(24'sd1000, 24'sd4, 24'sd4, 5);
      queue_word(LEVEL_MAX, 24'sd0, 24'sd0);
      queue_run(LEVEL_MIN, 24'sd8, 24'sd8, 6);
      queue_word(LEVEL_MIN, 24'sd3, 24'sd3);
      queue_word(LEVEL_MIN, 24'sd2, 24'sd2);
      wait_drained();

      for (int ph = 0; ph < 9; ph++) begin
         write_csr(CSR_MODE, MULT_W'(phase_mode[ph]));
         write_csr(CSR_TIME_MULT, phase_mult[ph]);
         n = 0;
         while (n < 52) begin
            if ($urandom_range(0, 9) < 2) begin
               queue_word(pick_level(), pick_time(), pick_time());
               n++;
            end else begin
               lvl  = pick_level();
               rt   = pick_time();
               ft   = pick_time();
               hold = $urandom_range(1, 24);
               for (int k = 0; k < hold; k++) begin
                  if ($urandom_range(0, 15) == 0) begin
                     rt = pick_time();
                     ft = pick_time();
                  end
                  queue_word(lvl, rt, ft);
                  n++;
               end
            end
         end
         wait_drained();
      end

      repeat (64) @(posedge clock);
      if (fail_count == 0 && slew_expect.size() == 0) begin
         $display("tb_timed_slew_limiter_core passed");
      end else begin
         $display("tb_timed_slew_limiter_core failed");
      end
      $finish;
   end

endmodule
